// ===== hw/rtl/intro_loop_outro_frame_sequencer_core_defines.svh =====
// Assertion macros shared by the frame sequencer RTL.
// Each macro expects signals named clock and reset in the enclosing module.
`ifndef INTRO_LOOP_OUTRO_FRAME_SEQUENCER_CORE_DEFINES_SVH
`define INTRO_LOOP_OUTRO_FRAME_SEQUENCER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ILOFS_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ILOFS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ilofs_pkg.sv =====
// Package for the intro/loop/outro frame sequencer.
// Holds field widths, codes, table structs and helper functions; no dependencies.
`default_nettype none

package ilofs_pkg;

   localparam int MaxFrames          = 16;
   localparam int DefaultImageIdBits = 16;

   localparam int PhaseW     = 2;
   localparam int SlotW      = 4;
   localparam int LenW       = 5;
   localparam int DurW       = 16;
   localparam int DeltaW     = 16;
   localparam int ImageW     = 16;
   localparam int ElapsedW   = 17;
   localparam int TableDepth = 3 * MaxFrames;
   localparam int TableAddrW = $clog2(TableDepth);
   localparam int CsrAddrW   = 4;
   localparam int CsrDataW   = 32;

   typedef enum logic [PhaseW-1:0] {
      PH_INTRO = 2'd0,
      PH_LOOP  = 2'd1,
      PH_OUTRO = 2'd2,
      PH_DONE  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      REQ_LOAD    = 2'd0,
      REQ_RESTART = 2'd1,
      REQ_STEP    = 2'd2,
      REQ_FINISH  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      CSR_INTRO_LEN = 2'd0,
      CSR_LOOP_LEN  = 2'd1,
      CSR_OUTRO_LEN = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                  en;
      logic [TableAddrW-1:0] addr;
      logic [DurW-1:0]       duration;
      logic [ImageW-1:0]     image;
   } tbl_wr_type;

   typedef struct packed {
      logic [TableAddrW-1:0] cur;
      logic [TableAddrW-1:0] nxt;
   } tbl_rd_addr_type;

   typedef struct packed {
      logic [DurW-1:0]         cur_duration;
      logic [ImageW-1:0]       cur_image;
      logic [ImageW-1:0]       nxt_image;
      logic [2:0][ImageW-1:0]  slot0_image;
   } tbl_rd_data_type;

   typedef struct packed {
      logic [PhaseW-1:0] phase;
      logic [SlotW-1:0]  frame_slot;
      logic [ImageW-1:0] image_id;
      logic              frame_valid;
      logic              frame_advanced;
   } rsp_item_type;

   // Flat table index of a frame slot within a phase.
   function automatic logic [TableAddrW-1:0] tbl_addr(input logic [PhaseW-1:0] ph,
                                                     input logic [SlotW-1:0] slot);
      return TableAddrW'(32'(ph) * MaxFrames + 32'(slot));
   endfunction

   // Lengths above the table capacity act as the capacity.
   function automatic logic [LenW-1:0] len_sat(input logic [LenW-1:0] raw);
      return (32'(raw) > MaxFrames) ? LenW'(MaxFrames) : raw;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ilofs_if.sv =====
// Handshake channel interfaces for the frame sequencer request and result streams.
// Depends on ilofs_pkg for field widths.
`default_nettype none

interface ilofs_req_if import ilofs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        req_type;
   logic [DeltaW-1:0] delta_ms;
   logic [PhaseW-1:0] table_phase;
   logic [SlotW-1:0]  table_slot;
   logic [DurW-1:0]   frame_duration;
   logic [ImageW-1:0] frame_image;

   modport source (output valid, req_type, delta_ms, table_phase, table_slot,
                   frame_duration, frame_image, input ready);
   modport sink   (input valid, req_type, delta_ms, table_phase, table_slot,
                   frame_duration, frame_image, output ready);
endinterface

interface ilofs_rsp_if import ilofs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [PhaseW-1:0] phase;
   logic [SlotW-1:0]  frame_slot;
   logic [ImageW-1:0] image_id;
   logic              frame_valid;
   logic              frame_advanced;

   modport source (output valid, phase, frame_slot, image_id, frame_valid, frame_advanced,
                   input ready);
   modport sink   (input valid, phase, frame_slot, image_id, frame_valid, frame_advanced,
                   output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ilofs_frame_table.sv =====
// Frame table memory: one write port, two registered read ports with write bypass,
// and shadow copies of slot 0 of each phase. Depends on ilofs_pkg.
`default_nettype none

module ilofs_frame_table import ilofs_pkg::*; #(
   parameter int IMAGE_ID_BITS = DefaultImageIdBits
) (
   input  wire logic            clock,
   input  wire tbl_wr_type      wr,
   input  wire tbl_rd_addr_type rd_addr,
   output tbl_rd_data_type      rd_data
);

   localparam int ImgW = (IMAGE_ID_BITS < ImageW) ? IMAGE_ID_BITS : ImageW;
   localparam int WordW = DurW + ImgW;

   logic [WordW-1:0] mem_ff [TableDepth];
   logic [WordW-1:0] cur_ff;
   logic [WordW-1:0] nxt_ff;
   logic [ImgW-1:0]  slot0_ff [3];
   logic [WordW-1:0] wr_word;

   assign wr_word = {wr.duration, wr.image[ImgW-1:0]};

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr_word;
      end
   end

   // Reads return the data being written in the same cycle.
   always_ff @(posedge clock) begin
      if (wr.en && (wr.addr == rd_addr.cur)) begin
         cur_ff <= wr_word;
      end else begin
         cur_ff <= mem_ff[rd_addr.cur];
      end
      if (wr.en && (wr.addr == rd_addr.nxt)) begin
         nxt_ff <= wr_word;
      end else begin
         nxt_ff <= mem_ff[rd_addr.nxt];
      end
   end

   // The first frame of each phase is needed on restart and on a phase change.
   always_ff @(posedge clock) begin
      for (int p = 0; p < 3; p++) begin
         if (wr.en && (wr.addr == TableAddrW'(p * MaxFrames))) begin
            slot0_ff[p] <= wr.image[ImgW-1:0];
         end
      end
   end

   always_comb begin
      rd_data.cur_duration = cur_ff[WordW-1:ImgW];
      rd_data.cur_image    = ImageW'(cur_ff[ImgW-1:0]);
      rd_data.nxt_image    = ImageW'(nxt_ff[ImgW-1:0]);
      for (int p = 0; p < 3; p++) begin
         rd_data.slot0_image[p] = ImageW'(slot0_ff[p]);
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/intro_loop_outro_frame_sequencer_core.sv =====
// Intro/loop/outro frame sequencer: top level with state, register port and result buffer.
// Depends on ilofs_pkg, ilofs_if, ilofs_frame_table and the assertion macro header.
//
// Usage:
// Request transactions arrive on req_chan (valid/ready). Each one is a table load,
// a restart, a time step or a finish request, and produces exactly one result
// transaction on rsp_chan with the phase, slot and image of the frame now shown.
// The phase lengths are written through the csr_ port (APB write, no
// wait states) while no request is in flight; reads return the stored lengths.
// All work for a request is done in the cycle it is accepted; the result is registered
// into the result buffer; while it is not full, a request can be accepted every cycle.
// The frame table answers from a synchronous memory whose read address follows
// the next frame position, so its data is ready by the next request.
// Results go through a two-entry buffer: a stalled receiver lets one more request
// in, and req_chan.ready drops only once both entries are full.
// Reset is synchronous and leaves the sequencer finished with the loop enabled and
// all phase lengths zero. The frame table is not cleared and must be loaded.
`default_nettype none
`include "intro_loop_outro_frame_sequencer_core_defines.svh"

module intro_loop_outro_frame_sequencer_core import ilofs_pkg::*; #(
   parameter int IMAGE_ID_BITS = DefaultImageIdBits
) (
   input  wire logic                clock,
   input  wire logic                reset,
   ilofs_req_if.sink                req_chan,
   ilofs_rsp_if.source              rsp_chan,
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [CsrAddrW-1:0] csr_paddr,
   input  wire logic [CsrDataW-1:0] csr_pwdata,
   output logic      [CsrDataW-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int ImgW = (IMAGE_ID_BITS < ImageW) ? IMAGE_ID_BITS : ImageW;

   phase_type           phase_ff, phase_in;
   logic [SlotW-1:0]    slot_ff, slot_in;
   logic [ElapsedW-1:0] elapsed_ff, elapsed_in;
   logic                loop_ok_ff, loop_ok_in;
   logic [LenW-1:0]     len_ff [3];

   rsp_item_type        res;
   rsp_item_type        out_ff, skid_ff;
   logic                out_v_ff, skid_v_ff;

   tbl_wr_type          wr;
   tbl_rd_addr_type     rd_addr;
   tbl_rd_data_type     rd_data;

   logic                acc, pop;
   req_kind_type        kind;
   logic [LenW-1:0]     len_intro, len_loop, len_outro, cur_len;
   logic                has_frame;
   logic [TableAddrW-1:0] cur_addr;
   logic [ImageW-1:0]   cur_image;
   logic [ElapsedW-1:0] sum;
   logic [LenW-1:0]     slot_inc;
   phase_type           nxt_phase;
   logic [ImageW-1:0]   nxt_slot0_image;
   csr_index_type       csr_index;
   logic                csr_wr;

   ilofs_frame_table #(
      .IMAGE_ID_BITS(IMAGE_ID_BITS)
   ) u_table (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---------------------------------------------------------------- register port
   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[CsrAddrW-1:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_index)
         CSR_INTRO_LEN: csr_prdata = CsrDataW'(len_ff[0]);
         CSR_LOOP_LEN:  csr_prdata = CsrDataW'(len_ff[1]);
         CSR_OUTRO_LEN: csr_prdata = CsrDataW'(len_ff[2]);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            len_ff[i] <= '0;
         end
      end else if (csr_wr) begin
         unique case (csr_index)
            CSR_INTRO_LEN: len_ff[0] <= csr_pwdata[LenW-1:0];
            CSR_LOOP_LEN:  len_ff[1] <= csr_pwdata[LenW-1:0];
            CSR_OUTRO_LEN: len_ff[2] <= csr_pwdata[LenW-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- sequencing
   assign acc  = req_chan.valid && req_chan.ready;
   assign pop  = rsp_chan.valid && rsp_chan.ready;
   assign kind = req_kind_type'(req_chan.req_type);

   assign len_intro = len_sat(len_ff[0]);
   assign len_loop  = len_sat(len_ff[1]);
   assign len_outro = len_sat(len_ff[2]);

   always_comb begin
      unique case (phase_ff)
         PH_INTRO: cur_len = len_intro;
         PH_LOOP:  cur_len = len_loop;
         PH_OUTRO: cur_len = len_outro;
         default:  cur_len = '0;
      endcase
   end

   assign has_frame = (phase_ff != PH_DONE) && ({1'b0, slot_ff} < cur_len);
   assign cur_addr  = tbl_addr(phase_ff, slot_ff);

   // Table write for a load transaction; slots past the table capacity are dropped.
   always_comb begin
      wr.en       = acc && (kind == REQ_LOAD) &&
                    (phase_type'(req_chan.table_phase) != PH_DONE) &&
                    (32'(req_chan.table_slot) < MaxFrames);
      wr.addr     = tbl_addr(req_chan.table_phase, req_chan.table_slot);
      wr.duration = req_chan.frame_duration;
      wr.image    = ImageW'(req_chan.frame_image[ImgW-1:0]);
   end

   assign cur_image = (wr.en && (wr.addr == cur_addr)) ? wr.image : rd_data.cur_image;
   assign sum       = elapsed_ff + ElapsedW'(req_chan.delta_ms);
   assign slot_inc  = {1'b0, slot_ff} + LenW'(1);

   // Phase that follows the current one once its last frame expires.
   always_comb begin
      unique case (phase_ff)
         PH_INTRO: begin
            if (loop_ok_ff && (len_loop != '0)) begin
               nxt_phase = PH_LOOP;
            end else if (len_outro != '0) begin
               nxt_phase = PH_OUTRO;
            end else begin
               nxt_phase = PH_DONE;
            end
         end
         PH_LOOP: begin
            if (loop_ok_ff) begin
               nxt_phase = PH_LOOP;
            end else if (len_outro != '0) begin
               nxt_phase = PH_OUTRO;
            end else begin
               nxt_phase = PH_DONE;
            end
         end
         default: nxt_phase = PH_DONE;
      endcase
   end

   always_comb begin
      phase_in         = phase_ff;
      slot_in          = slot_ff;
      elapsed_in       = elapsed_ff;
      loop_ok_in       = loop_ok_ff;
      res.frame_valid  = has_frame;
      res.image_id     = has_frame ? cur_image : '0;
      res.frame_advanced = 1'b0;
      if (acc) begin
         unique case (kind)
            REQ_LOAD: ;
            REQ_RESTART: begin
               slot_in    = '0;
               elapsed_in = '0;
               loop_ok_in = 1'b1;
               priority if (len_intro != '0) begin
                  phase_in = PH_INTRO;
               end else if (len_loop != '0) begin
                  phase_in = PH_LOOP;
               end else if (len_outro != '0) begin
                  phase_in = PH_OUTRO;
               end else begin
                  phase_in = PH_DONE;
               end
               res.frame_valid = (phase_in != PH_DONE);
               unique case (phase_in)
                  PH_INTRO: res.image_id = rd_data.slot0_image[0];
                  PH_LOOP:  res.image_id = rd_data.slot0_image[1];
                  PH_OUTRO: res.image_id = rd_data.slot0_image[2];
                  default:  res.image_id = '0;
               endcase
            end
            REQ_STEP: begin
               if ((phase_ff != PH_DONE) && (cur_len != '0)) begin
                  // A slot beyond a lowered length counts as an expired frame.
                  if (!has_frame || (sum >= ElapsedW'(rd_data.cur_duration))) begin
                     elapsed_in         = '0;
                     res.frame_advanced = 1'b1;
                     if (slot_inc < cur_len) begin
                        slot_in         = slot_inc[SlotW-1:0];
                        res.frame_valid = 1'b1;
                        res.image_id    = rd_data.nxt_image;
                     end else begin
                        phase_in        = nxt_phase;
                        slot_in         = '0;
                        res.frame_valid = (nxt_phase != PH_DONE);
                        res.image_id    = nxt_slot0_image;
                     end
                  end else begin
                     elapsed_in = sum;
                  end
               end
            end
            REQ_FINISH: begin
               if (phase_ff == PH_LOOP) begin
                  loop_ok_in = 1'b0;
               end
            end
            default: ;
         endcase
      end
      res.phase      = phase_in;
      res.frame_slot = slot_in;
   end

   always_comb begin
      unique case (nxt_phase)
         PH_LOOP:  nxt_slot0_image = rd_data.slot0_image[1];
         PH_OUTRO: nxt_slot0_image = rd_data.slot0_image[2];
         default:  nxt_slot0_image = '0;
      endcase
   end

   // The table is read at the position the state moves to, so its data is aligned
   // with the state register in the next cycle.
   always_comb begin
      if (phase_in == PH_DONE) begin
         rd_addr.cur = '0;
      end else begin
         rd_addr.cur = tbl_addr(phase_in, slot_in);
      end
      if ((phase_in == PH_DONE) || (32'(slot_in) >= MaxFrames - 1)) begin
         rd_addr.nxt = rd_addr.cur;
      end else begin
         rd_addr.nxt = tbl_addr(phase_in, slot_in + SlotW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_DONE;
         slot_ff    <= '0;
         elapsed_ff <= '0;
         loop_ok_ff <= 1'b1;
      end else begin
         phase_ff   <= phase_in;
         slot_ff    <= slot_in;
         elapsed_ff <= elapsed_in;
         loop_ok_ff <= loop_ok_in;
      end
   end

   // ---------------------------------------------------------------- result buffer
   assign req_chan.ready = !skid_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (pop || !out_v_ff) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff  <= acc;
         end
      end else if (acc) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop || !out_v_ff) begin
         if (skid_v_ff) begin
            out_ff <= skid_ff;
         end else if (acc) begin
            out_ff <= res;
         end
      end else if (acc) begin
         skid_ff <= res;
      end
   end

   assign rsp_chan.valid          = out_v_ff;
   assign rsp_chan.phase          = out_ff.phase;
   assign rsp_chan.frame_slot     = out_ff.frame_slot;
   assign rsp_chan.image_id       = out_ff.image_id;
   assign rsp_chan.frame_valid    = out_ff.frame_valid;
   assign rsp_chan.frame_advanced = out_ff.frame_advanced;

   // ---------------------------------------------------------------- assertions
   `ILOFS_ASSERT_IMPLIES(a_skid_behind_out, skid_v_ff, out_v_ff, "skid entry without output entry")
   `ILOFS_ASSERT_IMPLIES(a_done_slot_zero, phase_ff == PH_DONE, slot_ff == '0, "finished with nonzero slot")
   `ILOFS_ASSERT_IMPLIES(a_no_frame_no_image, out_v_ff && !out_ff.frame_valid, out_ff.image_id == '0, "image shown without a frame")
   `ILOFS_ASSERT_NEXT(a_restart_clears, acc && kind == REQ_RESTART, elapsed_ff == '0 && loop_ok_ff && slot_ff == '0, "restart left stale timing state")
   `ILOFS_ASSERT_NEXT(a_load_keeps_pos, acc && kind == REQ_LOAD, phase_ff == $past(phase_ff) && slot_ff == $past(slot_ff), "load moved the frame position")

endmodule

`default_nettype wire

// ===== tb/sv/intro_loop_outro_frame_sequencer_core_tb.sv =====
// Self-checking testbench for the intro/loop/outro frame sequencer core.
// Depends on ilofs_pkg, the ilofs_req_if/ilofs_rsp_if interfaces and the core itself;
// a local frame predictor checks every result transaction field by field.
module intro_loop_outro_frame_sequencer_core_tb;
   import ilofs_pkg::*;

   typedef struct packed {
      req_kind_type      kind;
      logic [DeltaW-1:0] delta;
      logic [PhaseW-1:0] tph;
      logic [SlotW-1:0]  tslot;
      logic [DurW-1:0]   dur;
      logic [ImageW-1:0] img;
   } seq_req_type;

   logic                clock;
   logic                reset;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CsrAddrW-1:0] csr_paddr;
   logic [CsrDataW-1:0] csr_pwdata;
   logic [CsrDataW-1:0] csr_prdata;
   logic                csr_pready;

   ilofs_req_if req_chan ();
   ilofs_rsp_if rsp_chan ();

   intro_loop_outro_frame_sequencer_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Predictor state: frame table, phase lengths and play position.
   logic [DurW-1:0]   frame_dur [TableDepth];
   logic [ImageW-1:0] frame_img [TableDepth];
   logic [LenW-1:0]   len_reg [3];
   phase_type         cur_phase;
   logic [SlotW-1:0]  cur_slot;
   logic [ElapsedW-1:0] elapsed;
   logic              loop_on;

   seq_req_type  pending_reqs [$];
   rsp_item_type shown_frames [$];
   seq_req_type  on_bus;

   int send_idle_pct;
   int recv_stall_pct;
   int n_errors;
   int n_accepted;
   int n_checked;
   int n_advances;
   int n_settings;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int eff_len(input int ph);
      if (ph > 2) return 0;
      return (int'(len_reg[ph]) > MaxFrames) ? MaxFrames : int'(len_reg[ph]);
   endfunction

   function automatic bit frame_present();
      return cur_phase != PH_DONE && int'(cur_slot) < eff_len(cur_phase);
   endfunction

   function automatic int cur_index();
      return int'(cur_phase) * MaxFrames + int'(cur_slot);
   endfunction

   function automatic void move_to_next_frame();
      int nslot;
      phase_type nph;
      nslot = int'(cur_slot) + 1;
      if (cur_phase != PH_DONE && nslot < eff_len(cur_phase)) begin
         cur_slot = SlotW'(nslot);
         return;
      end
      case (cur_phase)
         PH_INTRO: begin
            if (loop_on && eff_len(PH_LOOP) != 0) nph = PH_LOOP;
            else if (eff_len(PH_OUTRO) != 0) nph = PH_OUTRO;
            else nph = PH_DONE;
         end
         PH_LOOP: begin
            if (loop_on) nph = PH_LOOP;
            else if (eff_len(PH_OUTRO) != 0) nph = PH_OUTRO;
            else nph = PH_DONE;
         end
         default: nph = PH_DONE;
      endcase
      cur_phase = nph;
      cur_slot = '0;
   endfunction

   // Applies one request to the predictor and returns the frame it leaves on display.
   function automatic rsp_item_type predict_frame(input seq_req_type it);
      rsp_item_type r;
      int at;
      logic adv;
      logic expired;
      adv = 1'b0;
      case (it.kind)
         REQ_LOAD: begin
            if (it.tph <= 2) begin
               at = int'(it.tph) * MaxFrames + int'(it.tslot);
               frame_dur[at] = it.dur;
               frame_img[at] = it.img;
            end
         end
         REQ_RESTART: begin
            cur_slot = '0;
            elapsed = '0;
            loop_on = 1'b1;
            if (eff_len(PH_INTRO) != 0) cur_phase = PH_INTRO;
            else if (eff_len(PH_LOOP) != 0) cur_phase = PH_LOOP;
            else if (eff_len(PH_OUTRO) != 0) cur_phase = PH_OUTRO;
            else cur_phase = PH_DONE;
         end
         REQ_STEP: begin
            if (cur_phase != PH_DONE && eff_len(cur_phase) != 0) begin
               elapsed = elapsed + ElapsedW'(it.delta);
               // A slot left beyond a lowered length counts as an expired frame.
               if (!frame_present()) expired = 1'b1;
               else expired = elapsed >= ElapsedW'(frame_dur[cur_index()]);
               if (expired) begin
                  elapsed = '0;
                  move_to_next_frame();
                  adv = 1'b1;
               end
            end
         end
         default: begin
            if (cur_phase == PH_LOOP) loop_on = 1'b0;
         end
      endcase
      r.phase = cur_phase;
      r.frame_slot = cur_slot;
      r.frame_valid = frame_present();
      r.image_id = frame_present() ? frame_img[cur_index()] : '0;
      r.frame_advanced = adv;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      n_errors++;
   endtask

   // Request driver: predicts each transaction as it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            shown_frames.push_back(predict_frame(on_bus));
            n_accepted++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               on_bus = pending_reqs.pop_front();
               req_chan.valid          <= 1'b1;
               req_chan.req_type       <= on_bus.kind;
               req_chan.delta_ms       <= on_bus.delta;
               req_chan.table_phase    <= on_bus.tph;
               req_chan.table_slot     <= on_bus.tslot;
               req_chan.frame_duration <= on_bus.dur;
               req_chan.frame_image    <= on_bus.img;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (shown_frames.size() == 0) begin
               report_mismatch("result transaction with no request outstanding");
            end else begin
               want = shown_frames.pop_front();
               n_checked++;
               if (want.frame_advanced) n_advances++;
               if (rsp_chan.phase !== want.phase)
                  report_mismatch($sformatf("phase %0d, expected %0d",
                                            rsp_chan.phase, want.phase));
               if (rsp_chan.frame_slot !== want.frame_slot)
                  report_mismatch($sformatf("frame_slot %0d, expected %0d",
                                            rsp_chan.frame_slot, want.frame_slot));
               if (rsp_chan.image_id !== want.image_id)
                  report_mismatch($sformatf("image_id %h, expected %h",
                                            rsp_chan.image_id, want.image_id));
               if (rsp_chan.frame_valid !== want.frame_valid)
                  report_mismatch($sformatf("frame_valid %b, expected %b",
                                            rsp_chan.frame_valid, want.frame_valid));
               if (rsp_chan.frame_advanced !== want.frame_advanced)
                  report_mismatch($sformatf("frame_advanced %b, expected %b",
                                            rsp_chan.frame_advanced, want.frame_advanced));
            end
         end
         rsp_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic add_req(input req_kind_type kind, input int delta, input int tph,
                          input int tslot, input int dur, input int img);
      seq_req_type it;
      it.kind  = kind;
      it.delta = DeltaW'(delta);
      it.tph   = PhaseW'(tph);
      it.tslot = SlotW'(tslot);
      it.dur   = DurW'(dur);
      it.img   = ImageW'(img);
      pending_reqs.push_back(it);
   endtask

   task automatic add_step(input int delta);
      add_req(REQ_STEP, delta, 0, 0, 0, 0);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_chan.valid || shown_frames.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   // Register write followed by a read-back of the same register.
   task automatic set_phase_len(input csr_index_type idx, input int val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CsrAddrW'(4 * int'(idx));
      csr_pwdata  <= CsrDataW'(val);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      len_reg[idx] = LenW'(val);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      if (csr_prdata !== CsrDataW'(len_reg[idx]))
         report_mismatch($sformatf("register %0d reads %h, expected %h",
                                   int'(idx), csr_prdata, len_reg[idx]));
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_lengths(input int intro, input int loop_len, input int outro);
      set_phase_len(CSR_INTRO_LEN, intro);
      set_phase_len(CSR_LOOP_LEN, loop_len);
      set_phase_len(CSR_OUTRO_LEN, outro);
      n_settings++;
   endtask

   task automatic add_random_load(input bit any_dur);
      int dur;
      dur = (any_dur || $urandom_range(0, 99) < 15) ? $urandom_range(0, 65535)
                                                     : $urandom_range(0, 30);
      add_req(REQ_LOAD, 0, $urandom_range(0, 3), $urandom_range(0, 15), dur,
              $urandom_range(0, 65535));
   endtask

   // Mostly restart-then-play runs with random timing, with stray requests between them.
   task automatic add_random_reqs(input int count);
      int added;
      int run_len;
      int c;
      added = 0;
      while (added < count) begin
         if ($urandom_range(0, 99) < 75) begin
            add_req(REQ_RESTART, $urandom_range(0, 65535), $urandom_range(0, 3),
                    $urandom_range(0, 15), $urandom_range(0, 65535), $urandom_range(0, 65535));
            run_len = $urandom_range(4, 40);
            for (int j = 0; j < run_len; j++) begin
               c = $urandom_range(0, 99);
               if (c < 6) add_req(REQ_FINISH, 0, 0, 0, 0, 0);
               else if (c < 10) add_random_load(1'b0);
               else if (c < 15) add_step($urandom_range(0, 65535));
               else add_step($urandom_range(0, 24));
            end
            added += run_len + 1;
         end else begin
            if ($urandom_range(0, 1) == 1) add_random_load(1'b1);
            else add_req(req_kind_type'($urandom_range(0, 3)), $urandom_range(0, 65535),
                         $urandom_range(0, 3), $urandom_range(0, 15),
                         $urandom_range(0, 65535), $urandom_range(0, 65535));
            added++;
         end
      end
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         1: begin send_idle_pct = 48; recv_stall_pct = 0; end
         2: begin send_idle_pct = 0; recv_stall_pct = 48; end
         3: begin send_idle_pct = 33; recv_stall_pct = 33; end
         default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
   endtask

   initial begin
      #400000;
      $display("Run did not finish in time.");
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_chan.valid = 1'b0;
      req_chan.req_type = '0;
      req_chan.delta_ms = '0;
      req_chan.table_phase = '0;
      req_chan.table_slot = '0;
      req_chan.frame_duration = '0;
      req_chan.frame_image = '0;
      rsp_chan.ready = 1'b0;
      for (int i = 0; i < 3; i++) len_reg[i] = '0;
      cur_phase = PH_DONE;
      cur_slot = '0;
      elapsed = '0;
      loop_on = 1'b1;
      n_errors = 0;
      n_accepted = 0;
      n_checked = 0;
      n_advances = 0;
      n_settings = 0;
      set_idling(0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // All phases empty: a time step does nothing and restart lands in finished.
      add_step(5);
      add_req(REQ_RESTART, 0, 0, 0, 0, 0);
      add_req(REQ_LOAD, 0, 0, 0, 3, 16'hFFFF);
      add_req(REQ_LOAD, 0, 0, 1, 0, 16'h0001);
      add_req(REQ_LOAD, 0, 1, 0, 16'hFFFF, 16'hA5A5);
      add_req(REQ_LOAD, 0, 1, 1, 5, 16'h5A5A);
      add_req(REQ_LOAD, 0, 2, 0, 10, 16'h8000);
      add_req(REQ_LOAD, 0, 3, 15, 16'hFFFF, 16'hFFFF);
      add_req(REQ_LOAD, 0, 0, 15, 1, 16'h1234);
      wait_idle();
      set_lengths(2, 2, 1);

      // Full play-through: zero duration, maximum duration, finish inside the loop.
      add_req(REQ_RESTART, 0, 0, 0, 0, 0);
      add_step(65535);
      add_step(0);
      add_step(65535);
      add_req(REQ_FINISH, 0, 0, 0, 0, 0);
      add_step(5);
      add_step(9);
      add_step(1);
      add_step(65535);
      add_req(REQ_FINISH, 0, 0, 0, 0, 0);
      add_req(REQ_RESTART, 0, 0, 0, 0, 0);
      add_step(3);
      add_step(0);
      wait_idle();

      // Loop emptied while playing: no frame and no movement until a restart.
      set_phase_len(CSR_LOOP_LEN, 0);
      add_step(7);
      add_req(REQ_FINISH, 0, 0, 0, 0, 0);
      add_step(100);
      add_req(REQ_RESTART, 0, 0, 0, 0, 0);
      wait_idle();

      for (int p = 0; p < 8; p++) begin
         set_idling(p % 4);
         case (p)
            0: begin
               for (int k = 0; k < TableDepth; k++)
                  add_req(REQ_LOAD, 0, k / MaxFrames, k % MaxFrames,
                          $urandom_range(0, 30), $urandom_range(0, 65535));
            end
            1: set_lengths(16, 16, 16);
            2: set_lengths(31, 0, 17);
            3: set_lengths(0, 0, 0);
            4: set_lengths(1, 31, 1);
            default: set_lengths($urandom_range(0, 20), $urandom_range(0, 20),
                                 $urandom_range(0, 20));
         endcase
         if (p == 2) begin
            // Hold the request stream back until every outstanding result is in.
            add_random_reqs(120);
            wait_idle();
            add_random_reqs(120);
         end else begin
            add_random_reqs(p == 0 ? 200 : 240);
         end
         wait_idle();
      end

      repeat (10) @(posedge clock);
      $display("Covered %0d requests and %0d checked results over %0d length settings,",
               n_accepted, n_checked, n_settings);
      $display("with %0d frame advances and %0d mismatches.", n_advances, n_errors);
      if (n_errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
